/* rtl/bresenham_zone_counter_unit_macros.svh */
// assertion macros used by the zone counter controller
// expects clk_i and rst_ni in the scope of each use
`ifndef BRESENHAM_ZONE_COUNTER_UNIT_MACROS_SVH
`define BRESENHAM_ZONE_COUNTER_UNIT_MACROS_SVH

// checked only while out of reset
`define BZC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BZC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/bzc_pkg.sv */
// shared types and constants of the bresenham zone counter
// no dependencies
package bzc_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned GRID_W  = 9;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned ERR_W   = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [GRID_W-1:0] GRID_RESET = 9'd256;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TRACE = 1'b1;

  localparam logic [1:0] ZONE_CHOKE    = 2'd1;
  localparam logic [1:0] ZONE_CROSSING = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [1:0]         zone;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] choke_count;
    logic [CNT_W-1:0] crossing_count;
    logic             path_ok;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_trace;
    logic write_cell;
    logic step;
    logic fail;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic cell_bad;
    logic at_end;
  } status_t;

endpackage

/* rtl/bresenham_zone_counter_unit.sv */
// Bresenham zone counter. A zone map of MAX_SIDE x MAX_SIDE two-bit codes.
// Input channel (in_valid_i / in_stall_o, payload in_item_i): a write beat
// (mode 0) stores one zone code and gives no result. A trace beat
// (mode 1) walks the line from start to end cell and gives one result beat.
// A trace visits at most 256 cells and stops at the end cell, at a cell
// outside the grid or at the step limit; the walk reads the zone map through
// its single registered read port, one cell per cycle. The input stalls for
// the whole trace; the next beat is taken once the result sits in the output
// register, even while the receiver stalls it.
// Output channel (out_valid_o / out_stall_i, payload out_item_o): a result
// holds while stalled; a finished trace waits until the register is free.
// Config port (cfg_valid_i / cfg_ready_o, index 0 grid width, 1 grid height)
// is always ready; write it only while idle.
// Reset returns the grid size to 256 x 256 and empties the output register;
// the zone map is not cleared and cells must be written before they are read.
module bresenham_zone_counter_unit
  import bzc_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GRID_W-1:0]    cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  bzc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_item_i.mode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bzc_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

/* rtl/bzc_zone_mem.sv */
// zone map storage: one write port, one registered read port
// depends on nothing
module bzc_zone_mem #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [1:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [1:0]               rdata_o
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bzc_datapath.sv */
// line stepper, zone counters, grid registers and zone map
// depends on bzc_pkg and bzc_zone_mem
module bzc_datapath
  import bzc_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GRID_W-1:0]    cfg_data_i,
  input  in_item_t             in_item_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  output out_item_t            out_item_o
);

  localparam int unsigned MemDepth = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AddrW    = $clog2(MemDepth);

  logic [GRID_W-1:0]  gw_q, gh_q;
  logic [COORD_W-1:0] x_q, y_q, x1_q, y1_q, dx_q, dy_q;
  logic               sx_neg_q, sy_neg_q;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [STEP_W-1:0]  steps_q, limit_q;
  logic [CNT_W-1:0]   chokes_q, crossings_q;
  logic               ok_q, rd_pend_q;
  out_item_t          res_q;

  logic [COORD_W-1:0] dx_new, dy_new;
  logic signed [ERR_W:0] e2, dx_s, dy_s, err_sum;
  logic               mv_x, mv_y;
  logic [1:0]         rd_zone;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic               wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= GRID_RESET;
      gh_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GRID_WIDTH:  gw_q <= cfg_data_i;
        REG_GRID_HEIGHT: gh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dx_new = (in_item_i.end_x > in_item_i.start_x) ?
                  in_item_i.end_x - in_item_i.start_x : in_item_i.start_x - in_item_i.end_x;
  assign dy_new = (in_item_i.end_y > in_item_i.start_y) ?
                  in_item_i.end_y - in_item_i.start_y : in_item_i.start_y - in_item_i.end_y;

  assign dx_s    = $signed({{(ERR_W+1-COORD_W){1'b0}}, dx_q});
  assign dy_s    = $signed({{(ERR_W+1-COORD_W){1'b0}}, dy_q});
  assign e2      = $signed({err_q, 1'b0});
  assign mv_x    = e2 > -dy_s;
  assign mv_y    = e2 < dx_s;
  assign err_sum = $signed({err_q[ERR_W-1], err_q}) - (mv_x ? dy_s : '0) + (mv_y ? dx_s : '0);
  assign err_d   = ERR_W'(err_sum);

  assign status_o.limit_hit = steps_q >= limit_q;
  assign status_o.cell_bad  = ({1'b0, x_q} >= gw_q) || ({1'b0, y_q} >= gh_q) ||
                              (32'(x_q) >= MAX_SIDE) || (32'(y_q) >= MAX_SIDE);
  assign status_o.at_end    = (x_q == x1_q) && (y_q == y1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_trace) begin
      x_q      <= in_item_i.start_x;
      y_q      <= in_item_i.start_y;
      x1_q     <= in_item_i.end_x;
      y1_q     <= in_item_i.end_y;
      dx_q     <= dx_new;
      dy_q     <= dy_new;
      sx_neg_q <= !(in_item_i.start_x < in_item_i.end_x);
      sy_neg_q <= !(in_item_i.start_y < in_item_i.end_y);
      err_q    <= ERR_W'($signed({3'b000, dx_new}) - $signed({3'b000, dy_new}));
      steps_q  <= '0;
      limit_q  <= STEP_W'(gw_q) + STEP_W'(gh_q);
    end else if (cmd_i.step && !status_o.at_end) begin
      if (mv_x) begin
        x_q <= sx_neg_q ? x_q - 1'b1 : x_q + 1'b1;
      end
      if (mv_y) begin
        y_q <= sy_neg_q ? y_q - 1'b1 : y_q + 1'b1;
      end
      err_q   <= err_d;
      steps_q <= steps_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_trace) begin
      chokes_q    <= '0;
      crossings_q <= '0;
      ok_q        <= 1'b1;
    end else begin
      if (rd_pend_q && rd_zone == ZONE_CHOKE) begin
        chokes_q <= chokes_q + 1'b1;
      end
      if (rd_pend_q && rd_zone == ZONE_CROSSING) begin
        crossings_q <= crossings_q + 1'b1;
      end
      if (cmd_i.fail) begin
        ok_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q.choke_count    <= chokes_q;
      res_q.crossing_count <= crossings_q;
      res_q.path_ok        <= ok_q;
    end
  end

  assign out_item_o = res_q;

  assign rd_addr = AddrW'(32'(y_q) * MAX_SIDE + 32'(x_q));
  assign wr_addr = AddrW'(32'(in_item_i.cell_y) * MAX_SIDE + 32'(in_item_i.cell_x));
  assign wr_en   = cmd_i.write_cell && (32'(in_item_i.cell_x) < MAX_SIDE) &&
                   (32'(in_item_i.cell_y) < MAX_SIDE);

  bzc_zone_mem #(
    .DEPTH (MemDepth)
  ) u_zone_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_item_i.zone),
    .re_i    (cmd_i.step),
    .raddr_i (rd_addr),
    .rdata_o (rd_zone)
  );

endmodule

/* rtl/bzc_ctrl.sv */
// controller state machine: input handshake, walk sequencing, result register valid
// depends on bzc_pkg and the assertion macro header
`include "bresenham_zone_counter_unit_macros.svh"
module bzc_ctrl
  import bzc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_mode_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept, out_free;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && in_mode_i == MODE_TRACE) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.limit_hit || status_i.cell_bad || status_i.at_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_trace = in_accept && in_mode_i == MODE_TRACE;
        cmd_o.write_cell = in_accept && in_mode_i == MODE_WRITE;
      end
      ST_WALK: begin
        cmd_o.step = !status_i.limit_hit && !status_i.cell_bad;
        cmd_o.fail = !status_i.limit_hit && status_i.cell_bad;
      end
      ST_DRAIN: ;
      ST_DONE: cmd_o.res_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BZC_ASSERT(a_trace_starts_walk, cmd_o.load_trace |=> state_q == ST_WALK, "trace did not start a walk")
  `BZC_ASSERT(a_res_load_free, cmd_o.res_load |-> (!out_valid_q || !out_stall_i), "result overwrote a waiting beat")
  `BZC_ASSERT(a_drain_to_done, state_q == ST_DRAIN |=> state_q == ST_DONE, "drain did not reach done")
  `BZC_ASSERT_ALWAYS(a_no_step_on_bad, !(cmd_o.step && cmd_o.fail), "step and fail together")

endmodule

/* verif/bresenham_zone_counter_unit_test.sv */
// testbench for bresenham_zone_counter_unit: zone writes and line traces checked
// against a line walk kept in the bench, under random idling and backpressure
// depends on bzc_pkg and the bresenham_zone_counter_unit rtl
module bresenham_zone_counter_unit_test
  import bzc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_SIDE      = 256;
  localparam int unsigned WINDOW        = 24;
  localparam int unsigned PHASE_BEATS   = 220;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam logic [1:0]  ZONE_OTHER    = 2'd0;
  localparam logic [1:0]  ZONE_SPARE    = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_item_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [GRID_W-1:0]    cfg_data_i;

  logic [1:0]  zone_map [MAP_SIDE*MAP_SIDE];
  bit          cell_written [MAP_SIDE*MAP_SIDE];
  int unsigned grid_w = 256;
  int unsigned grid_h = 256;
  out_item_t   tally_q [$];
  logic [15:0] unwritten_cells [$];
  int unsigned beats_sent = 0;
  int unsigned idle_pct = 32;
  bit          hold_request = 1'b0;
  bit          mismatch_seen = 1'b0;

  bresenham_zone_counter_unit #(
    .MAX_SIDE(MAP_SIDE)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bit take_break();
    return idle_pct != 0 && $urandom_range(99) < idle_pct;
  endfunction

  // walks the line over the bench's own zone map; notes cells never written
  function automatic out_item_t walk_line(in_item_t beat);
    int          x0, y0, x1, y1, dx, dy, sx, sy, err, e2;
    int unsigned limit_steps, steps;
    logic [15:0] idx;
    bit          done;
    out_item_t   tally;
    x0 = int'(beat.start_x);
    y0 = int'(beat.start_y);
    x1 = int'(beat.end_x);
    y1 = int'(beat.end_y);
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    limit_steps = grid_w + grid_h;
    steps = 0;
    done = 1'b0;
    tally.choke_count = '0;
    tally.crossing_count = '0;
    tally.path_ok = 1'b1;
    while (!done && steps < limit_steps) begin
      if (x0 < 0 || y0 < 0 || x0 >= int'(grid_w) || x0 >= int'(MAP_SIDE) ||
          y0 >= int'(grid_h) || y0 >= int'(MAP_SIDE)) begin
        tally.path_ok = 1'b0;
        done = 1'b1;
      end else begin
        idx = {8'(y0), 8'(x0)};
        if (!cell_written[idx]) unwritten_cells.push_back(idx);
        if (zone_map[idx] === ZONE_CHOKE) tally.choke_count = tally.choke_count + 1'b1;
        if (zone_map[idx] === ZONE_CROSSING) begin
          tally.crossing_count = tally.crossing_count + 1'b1;
        end
        if (x0 == x1 && y0 == y1) begin
          done = 1'b1;
        end else begin
          e2 = 2 * err;
          if (e2 > -dy) begin
            err -= dy;
            x0 += sx;
          end
          if (e2 < dx) begin
            err += dx;
            y0 += sy;
          end
          steps++;
        end
      end
    end
    return tally;
  endfunction

  function automatic in_item_t random_beat();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [7:0] near_coord(int unsigned side);
    int unsigned top;
    top = ((side < WINDOW) ? side : WINDOW) + 2;
    if (top > 255) top = 255;
    return 8'($urandom_range(top));
  endfunction

  task automatic send_beat(in_item_t beat);
    bit taken;
    if (beat.mode == MODE_WRITE) begin
      zone_map[{beat.cell_y, beat.cell_x}] = beat.zone;
      cell_written[{beat.cell_y, beat.cell_x}] = 1'b1;
    end else begin
      tally_q.push_back(walk_line(beat));
    end
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= beat;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    beats_sent++;
  endtask

  // every cell the walk will read gets a zone first
  task automatic send_item(in_item_t beat);
    in_item_t fill;
    if (beat.mode == MODE_TRACE) begin
      unwritten_cells.delete();
      void'(walk_line(beat));
      while (unwritten_cells.size() != 0) begin
        fill = random_beat();
        fill.mode = MODE_WRITE;
        fill.cell_x = unwritten_cells[0][7:0];
        fill.cell_y = unwritten_cells[0][15:8];
        void'(unwritten_cells.pop_front());
        send_beat(fill);
      end
    end
    send_beat(beat);
  endtask

  task automatic put_zone(logic [7:0] x, logic [7:0] y, logic [1:0] zone);
    in_item_t beat;
    beat = random_beat();
    beat.mode = MODE_WRITE;
    beat.cell_x = x;
    beat.cell_y = y;
    beat.zone = zone;
    send_item(beat);
  endtask

  task automatic trace(logic [7:0] x0, logic [7:0] y0, logic [7:0] x1, logic [7:0] y1);
    in_item_t beat;
    beat = random_beat();
    beat.mode = MODE_TRACE;
    beat.start_x = x0;
    beat.start_y = y0;
    beat.end_x = x1;
    beat.end_y = y1;
    send_item(beat);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GRID_W-1:0] value);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_grid(logic [GRID_W-1:0] w, logic [GRID_W-1:0] h);
    drain();
    write_reg(REG_GRID_WIDTH, w);
    grid_w = 32'(w);
    write_reg(REG_GRID_HEIGHT, h);
    grid_h = 32'(h);
  endtask

  function automatic in_item_t random_item();
    in_item_t    beat;
    int unsigned roll;
    beat = random_beat();
    roll = $urandom_range(99);
    if (roll < 30) begin
      beat.mode = MODE_WRITE;
      if ($urandom_range(1)) begin
        beat.cell_x = near_coord(grid_w);
        beat.cell_y = near_coord(grid_h);
      end
    end else begin
      beat.mode = MODE_TRACE;
      if (roll < 33) begin
        // long lines stay in a narrow band along one edge
        if ($urandom_range(1)) begin
          beat.start_y = 8'($urandom_range(3));
          beat.end_y = 8'($urandom_range(3));
        end else begin
          beat.start_x = 8'($urandom_range(3));
          beat.end_x = 8'($urandom_range(3));
        end
      end else begin
        beat.start_x = near_coord(grid_w);
        beat.start_y = near_coord(grid_h);
        beat.end_x = near_coord(grid_w);
        beat.end_y = near_coord(grid_h);
      end
    end
    return beat;
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) send_item(random_item());
  endtask

  task automatic test_zone_codes();
    put_zone(8'd0, 8'd0, ZONE_CHOKE);
    put_zone(8'd255, 8'd255, ZONE_CROSSING);
    put_zone(8'd255, 8'd0, ZONE_SPARE);
    put_zone(8'd0, 8'd255, ZONE_OTHER);
    trace(8'd0, 8'd0, 8'd0, 8'd0);
    trace(8'd255, 8'd255, 8'd255, 8'd255);
    trace(8'd255, 8'd0, 8'd255, 8'd0);
    trace(8'd0, 8'd255, 8'd0, 8'd255);
    trace(8'd3, 8'd1, 8'd9, 8'd4);
    trace(8'd9, 8'd4, 8'd3, 8'd1);
    trace(8'd5, 8'd9, 8'd6, 8'd2);
  endtask

  task automatic test_grid_bounds();
    set_grid(9'd1, 9'd1);
    trace(8'd0, 8'd0, 8'd255, 8'd255);
    trace(8'd255, 8'd255, 8'd0, 8'd0);
    set_grid(9'd8, 9'd6);
    trace(8'd2, 8'd2, 8'd20, 8'd5);
    trace(8'd7, 8'd0, 8'd7, 8'd9);
    // no steps allowed at all
    set_grid(9'd0, 9'd0);
    trace(8'd0, 8'd0, 8'd4, 8'd4);
    set_grid(9'd0, 9'd5);
    trace(8'd0, 8'd0, 8'd0, 8'd0);
    set_grid(9'd511, 9'd511);
    trace(8'd250, 8'd255, 8'd255, 8'd250);
    set_grid(9'd256, 9'd1);
    trace(8'd0, 8'd0, 8'd255, 8'd0);
  endtask

  task automatic test_backpressure();
    set_grid(9'd256, 9'd256);
    hold_request = 1'b1;
    for (int i = 0; i < 16; i++) begin
      trace(near_coord(grid_w), near_coord(grid_h), near_coord(grid_w), near_coord(grid_h));
    end
  endtask

  task automatic test_random_grids();
    set_grid(9'd256, 9'd256);
    run_random(PHASE_BEATS);
    set_grid(9'($urandom_range(1, 32)), 9'($urandom_range(1, 32)));
    run_random(PHASE_BEATS);
    set_grid(9'd1, 9'd256);
    run_random(PHASE_BEATS);
    set_grid(9'd256, 9'd1);
    run_random(PHASE_BEATS);
    set_grid(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)));
    run_random(PHASE_BEATS);
  endtask

  task automatic test_no_idling();
    set_grid(9'd20, 9'd20);
    idle_pct = 0;
    run_random(PHASE_BEATS);
    idle_pct = 32;
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= take_break();
      end
    end
  end

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
      mismatch_seen = 1'b1;
    end
  endfunction

  initial begin
    out_item_t seen, want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        seen = out_item_o;
        if (tally_q.size() == 0) begin
          $display("%0t: result beat with none expected, actual %p", $time, seen);
          mismatch_seen = 1'b1;
        end else begin
          want = tally_q.pop_front();
          check_field("choke_count", want.choke_count, seen.choke_count);
          check_field("crossing_count", want.crossing_count, seen.crossing_count);
          check_field("path_ok", CNT_W'(want.path_ok), CNT_W'(seen.path_ok));
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zone_codes();
    test_grid_bounds();
    test_backpressure();
    test_random_grids();
    test_no_idling();
    drain();
    if (!mismatch_seen && tally_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bzc_pkg.sv
rtl/bzc_zone_mem.sv
rtl/bzc_datapath.sv
rtl/bzc_ctrl.sv
rtl/bresenham_zone_counter_unit.sv
verif/bresenham_zone_counter_unit_test.sv
